// ===== src/tvbc_pkg.sv =====
// ----------------------------------------------------------------------------
// tvbc_pkg
// Shared types, constants and the round mixing function of the block cipher.
// ----------------------------------------------------------------------------
package tvbc_pkg;

    localparam int unsigned ROUND_COUNT = 32;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned KEY_WORDS   = 4;
    localparam int unsigned CFG_INDEX_W = 8;

    localparam logic [WORD_W-1:0] TEA_STEP = 32'h9E37_79B9;
    localparam logic [63:0]       SUM_FULL = 64'(TEA_STEP) * 64'(ROUND_COUNT);
    localparam logic [WORD_W-1:0] DEC_SUM  = SUM_FULL[WORD_W-1:0];

    localparam logic [WORD_W-1:0] KEY0_RESET = 32'h0123_4567;
    localparam logic [WORD_W-1:0] KEY1_RESET = 32'h89AB_CDEF;
    localparam logic [WORD_W-1:0] KEY2_RESET = 32'hFEDC_BA98;
    localparam logic [WORD_W-1:0] KEY3_RESET = 32'h7654_3210;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD0 = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD1 = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD2 = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD3 = 8'd3;

    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] out_first_word;
        logic [WORD_W-1:0] out_second_word;
    } t_out_item;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] t_key;

    typedef struct packed {
        logic              dec;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] acc;
    } t_stage;

    function automatic logic [WORD_W-1:0] mix(
        input logic [WORD_W-1:0] x,
        input logic [WORD_W-1:0] s,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
    endfunction

endpackage

// ===== src/tvbc_round_cell.sv =====
// ----------------------------------------------------------------------------
// tvbc_round_cell
// One cipher round as two registered half-rounds, forward or backward.
// ----------------------------------------------------------------------------
module tvbc_round_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  tvbc_pkg::t_key  i_key,
    input  logic            i_valid,
    input  tvbc_pkg::t_stage i_stage,
    output logic            o_valid,
    output tvbc_pkg::t_stage o_stage
);
    import tvbc_pkg::*;

    logic   r_mid_valid;
    t_stage r_mid;
    t_stage n_mid;
    logic   r_out_valid;
    t_stage r_out;
    t_stage n_out;

    logic [WORD_W-1:0] h1_x;
    logic [WORD_W-1:0] h1_m;
    logic [WORD_W-1:0] h2_x;
    logic [WORD_W-1:0] h2_m;

    // first half: old sum
    always_comb begin
        n_mid = i_stage;
        if (i_stage.dec == ACT_DECRYPT) begin
            h1_x      = i_stage.a;
            h1_m      = mix(h1_x, i_stage.acc, i_key[2], i_key[3]);
            n_mid.b   = i_stage.b - h1_m;
            n_mid.acc = i_stage.acc - TEA_STEP;
        end else begin
            h1_x      = i_stage.b;
            h1_m      = mix(h1_x, i_stage.acc, i_key[0], i_key[1]);
            n_mid.a   = i_stage.a + h1_m;
            n_mid.acc = i_stage.acc + TEA_STEP;
        end
    end

    // second half: new sum
    always_comb begin
        n_out = r_mid;
        if (r_mid.dec == ACT_DECRYPT) begin
            h2_x    = r_mid.b;
            h2_m    = mix(h2_x, r_mid.acc, i_key[0], i_key[1]);
            n_out.a = r_mid.a - h2_m;
        end else begin
            h2_x    = r_mid.a;
            h2_m    = mix(h2_x, r_mid.acc, i_key[2], i_key[3]);
            n_out.b = r_mid.b + h2_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_mid_valid <= i_valid;
            r_out_valid <= r_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid <= n_mid;
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_stage = r_out;

endmodule

// ===== src/tea_variant_block_cipher.sv =====
// ----------------------------------------------------------------------------
// tea_variant_block_cipher
// 64-bit TEA-style block cipher, 32 rounds under a 128-bit key.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_ready carry an item with the action (0 encrypt,
// 1 decrypt) and the two words of the block. Output channel: o_valid /
// i_ready carry the two words of the transformed block, in input order.
// Config channel: i_cfg_valid / o_cfg_ready write key word i_cfg_index
// (0 to 3) with i_cfg_data; other indexes are dropped. o_cfg_ready is
// always high. The user must write keys only while no item is in flight;
// the block does not enforce this. An item runs from accept to o_valid
// through the row of round cells, each round split into two registered
// half-rounds, and then through the output register.
// Throughput: one item per cycle while the receiver takes results.
// When the receiver stalls, the row keeps moving and accepting items
// until a finished item reaches its end with the output register still
// full; then the whole row holds and o_ready drops.
// Reset: no item in flight and the four key words at their reset values.
// ----------------------------------------------------------------------------
module tea_variant_block_cipher (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  tvbc_pkg::t_in_item                 i_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output tvbc_pkg::t_out_item                o_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tvbc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [tvbc_pkg::WORD_W-1:0]        i_cfg_data
);
    import tvbc_pkg::*;

    t_key      r_key;
    logic      r_out_valid;
    t_out_item r_out;
    logic      en;
    logic      out_load;
    t_stage    first_stage;

    logic   c_valid [ROUND_COUNT+1];
    t_stage c_stage [ROUND_COUNT+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0] <= KEY0_RESET;
            r_key[1] <= KEY1_RESET;
            r_key[2] <= KEY2_RESET;
            r_key[3] <= KEY3_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_KEY_WORD0: r_key[0] <= i_cfg_data;
                REG_KEY_WORD1: r_key[1] <= i_cfg_data;
                REG_KEY_WORD2: r_key[2] <= i_cfg_data;
                REG_KEY_WORD3: r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    assign en       = !(c_valid[ROUND_COUNT] && r_out_valid && !i_ready);
    assign out_load = !r_out_valid || i_ready;
    assign o_ready  = en;

    always_comb begin
        first_stage.dec = i_data.action;
        first_stage.a   = i_data.first_word;
        first_stage.b   = i_data.second_word;
        first_stage.acc = (i_data.action == ACT_DECRYPT) ? DEC_SUM : '0;
    end

    assign c_valid[0] = i_valid;
    assign c_stage[0] = first_stage;

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        tvbc_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_key   (r_key),
            .i_valid (c_valid[g]),
            .i_stage (c_stage[g]),
            .o_valid (c_valid[g+1]),
            .o_stage (c_stage[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= c_valid[ROUND_COUNT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.out_first_word  <= c_stage[ROUND_COUNT].a;
            r_out.out_second_word <= c_stage[ROUND_COUNT].b;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // row only holds when a finished item is blocked at its end
    a_hold_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (c_valid[ROUND_COUNT] && o_valid && !i_ready))
        else $error("row held without a blocked item");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> g_round[0].u_cell.r_mid_valid)
        else $error("accepted item did not enter the first cell");

    a_blocked_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_valid[ROUND_COUNT] && o_valid && !i_ready) |=>
        (c_valid[ROUND_COUNT] && $stable(c_stage[ROUND_COUNT])))
        else $error("blocked item at end of row was lost");

endmodule
